// ===== rtl/dsu_pkg.sv =====
`timescale 1ns / 1ps

package dsu_pkg;

    // Table geometry
    localparam int NODES  = 1024;
    localparam int NODE_W = $clog2(NODES);
    localparam int SIZE_W = NODE_W + 1;
    localparam int OUT_W  = 10;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Microprogram step addresses
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc UPC_CLR    = 4'd0;
    localparam t_upc UPC_IDLE   = 4'd1;
    localparam t_upc UPC_LDA    = 4'd2;
    localparam t_upc UPC_WALKA  = 4'd3;
    localparam t_upc UPC_BRANCH = 4'd4;
    localparam t_upc UPC_WALKB  = 4'd5;
    localparam t_upc UPC_TEST   = 4'd6;
    localparam t_upc UPC_LINK   = 4'd7;
    localparam t_upc UPC_QOUT   = 4'd8;

    // Source of the walk cursor (also the memory read address)
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_NA,
        CUR_NB,
        CUR_PAR
    } t_cur_sel;

    // Which root/size pair captures the walk result
    typedef enum logic [1:0] {
        SAVE_NONE,
        SAVE_RA,
        SAVE_RB
    } t_save_sel;

    // Branch conditions reported by the datapath
    typedef enum logic [2:0] {
        COND_ACCEPT,
        COND_CLR_LAST,
        COND_ROOT,
        COND_QUERY,
        COND_SAME,
        COND_OUT_FREE
    } t_cond;

    // Sequencing mode of a control word
    typedef enum logic [1:0] {
        NXT_STEP,
        NXT_JUMP,
        NXT_JUMP_IF,
        NXT_WAIT_IF
    } t_nxt;

    typedef struct packed {
        logic      ready;
        t_cur_sel  cur_sel;
        t_save_sel save_sel;
        logic      link_wr;
        logic      out_ld;
        logic      clr;
    } t_ctrl;

    typedef struct packed {
        logic accept;
        logic clr_last;
        logic root;
        logic query;
        logic same;
        logic out_free;
    } t_stat;

    typedef struct packed {
        t_ctrl ctrl;
        t_nxt  nxt;
        t_cond cond;
        t_upc  target;
    } t_uword;

endpackage

// ===== rtl/dsu_if.sv =====
`timescale 1ns / 1ps

// Request channel: one join or query per transfer
interface dsu_in_if import dsu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, output action, output node_a, output node_b, input ready);
    modport sink   (input valid, input action, input node_a, input node_b, output ready);
endinterface

// Result channel: one count of the other members of the set per query
interface dsu_out_if import dsu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] others_in_set;

    modport source (output valid, output others_in_set, input ready);
    modport sink   (input valid, input others_in_set, output ready);
endinterface

// ===== rtl/disjoint_set_union_by_size_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// i_item    in   valid/ready   action, node_a, node_b
// o_result  out  valid/ready   others_in_set
//
// After reset a clearing pass writes every link and size entry, with
// i_item.ready low. A join of two nodes that already share a root skips the
// link write. The root walk reads one level per cycle through the single
// read port of the link memory; a node's depth in its tree is at most
// log2(NODES) = 10.
// One request is in work at a time; a finished result waits in the output
// register, and only a query that completes while it still waits is held.

module disjoint_set_union_by_size_unit import dsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsu_in_if.sink    i_item,
    dsu_out_if.source o_result
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    // Control store and step counter
    dsu_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Memories, walk registers and result register
    dsu_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat),
        .i_item  (i_item),
        .o_res   (o_result)
    );

endmodule

// ===== rtl/dsu_useq.sv =====
`timescale 1ns / 1ps

module dsu_useq import dsu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    // Control store: one word per step
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w.ctrl = '{ready: 1'b0, cur_sel: CUR_HOLD, save_sel: SAVE_NONE,
                   link_wr: 1'b0, out_ld: 1'b0, clr: 1'b0};
        w.nxt    = NXT_JUMP;
        w.cond   = COND_ACCEPT;
        w.target = UPC_IDLE;
        unique case (pc)
            UPC_CLR: begin
                w.ctrl.clr = 1'b1;
                w.nxt      = NXT_WAIT_IF;
                w.cond     = COND_CLR_LAST;
                w.target   = UPC_IDLE;
            end
            UPC_IDLE: begin
                w.ctrl.ready = 1'b1;
                w.nxt        = NXT_WAIT_IF;
                w.cond       = COND_ACCEPT;
                w.target     = UPC_LDA;
            end
            UPC_LDA: begin
                w.ctrl.cur_sel = CUR_NA;
                w.nxt          = NXT_STEP;
            end
            UPC_WALKA: begin
                w.ctrl.cur_sel  = CUR_PAR;
                w.ctrl.save_sel = SAVE_RA;
                w.nxt           = NXT_WAIT_IF;
                w.cond          = COND_ROOT;
                w.target        = UPC_BRANCH;
            end
            UPC_BRANCH: begin
                w.ctrl.cur_sel = CUR_NB;
                w.nxt          = NXT_JUMP_IF;
                w.cond         = COND_QUERY;
                w.target       = UPC_QOUT;
            end
            UPC_WALKB: begin
                w.ctrl.cur_sel  = CUR_PAR;
                w.ctrl.save_sel = SAVE_RB;
                w.nxt           = NXT_WAIT_IF;
                w.cond          = COND_ROOT;
                w.target        = UPC_TEST;
            end
            UPC_TEST: begin
                w.nxt    = NXT_JUMP_IF;
                w.cond   = COND_SAME;
                w.target = UPC_IDLE;
            end
            UPC_LINK: begin
                w.ctrl.link_wr = 1'b1;
                w.nxt          = NXT_JUMP;
                w.target       = UPC_IDLE;
            end
            UPC_QOUT: begin
                w.ctrl.out_ld = 1'b1;
                w.nxt         = NXT_WAIT_IF;
                w.cond        = COND_OUT_FREE;
                w.target      = UPC_IDLE;
            end
            default: begin
                w.nxt    = NXT_JUMP;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_cur;
    logic   w_hit;

    assign w_cur  = ucode(r_upc);
    assign o_ctrl = w_cur.ctrl;

    // Select the branch condition
    always_comb begin
        unique case (w_cur.cond)
            COND_ACCEPT:   w_hit = i_stat.accept;
            COND_CLR_LAST: w_hit = i_stat.clr_last;
            COND_ROOT:     w_hit = i_stat.root;
            COND_QUERY:    w_hit = i_stat.query;
            COND_SAME:     w_hit = i_stat.same;
            COND_OUT_FREE: w_hit = i_stat.out_free;
            default:       w_hit = 1'b0;
        endcase
    end

    // Advance, jump or hold the step counter
    always_comb begin
        unique case (w_cur.nxt)
            NXT_STEP:    n_upc = r_upc + t_upc'(1);
            NXT_JUMP:    n_upc = w_cur.target;
            NXT_JUMP_IF: n_upc = w_hit ? w_cur.target : r_upc + t_upc'(1);
            NXT_WAIT_IF: n_upc = w_hit ? w_cur.target : r_upc;
            default:     n_upc = UPC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    // An accepted request always starts the first root walk
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.accept |=> (r_upc == UPC_LDA))
        else $error("accepted request did not start the walk");

    // The step counter never leaves the written program
    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc <= UPC_QOUT)
        else $error("step counter outside the program");

    // A join always goes on to the second walk
    a_join_walks_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_BRANCH && !i_stat.query) |=> (r_upc == UPC_WALKB))
        else $error("join skipped the second walk");

endmodule

// ===== rtl/dsu_dpath.sv =====
`timescale 1ns / 1ps

module dsu_dpath import dsu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    dsu_in_if.sink      i_item,
    dsu_out_if.source   o_res
);

    // Link and size memories
    logic [NODE_W-1:0] mem_par  [NODES];
    logic [SIZE_W-1:0] mem_size [NODES];
    logic [NODE_W-1:0] r_qpar;
    logic [SIZE_W-1:0] r_qsize;

    logic              r_act;
    logic [NODE_W-1:0] r_na;
    logic [NODE_W-1:0] r_nb;
    logic [NODE_W-1:0] r_cur;
    logic [NODE_W-1:0] n_cur;
    logic [NODE_W-1:0] r_ra;
    logic [NODE_W-1:0] r_rb;
    logic [SIZE_W-1:0] r_sa;
    logic [SIZE_W-1:0] r_sb;
    logic [NODE_W-1:0] r_clr;
    logic [OUT_W-1:0]  r_out;
    logic              r_ovalid;

    logic              w_accept;
    logic              w_out_free;
    logic              w_a_big;
    logic [SIZE_W-1:0] w_sum;
    logic [SIZE_W-1:0] w_less;
    logic [OUT_W-1:0]  w_sat;
    logic              w_par_we;
    logic [NODE_W-1:0] w_par_wa;
    logic [NODE_W-1:0] w_par_wd;
    logic              w_size_we;
    logic [NODE_W-1:0] w_size_wa;
    logic [SIZE_W-1:0] w_size_wd;

    assign w_accept   = i_item.valid && i_ctrl.ready;
    assign w_out_free = !r_ovalid || o_res.ready;
    assign w_a_big    = r_sa > r_sb;
    assign w_sum      = r_sa + r_sb;
    assign w_less     = r_sa - SIZE_W'(1);
    assign w_sat      = (w_less > SIZE_W'(OUT_MAX)) ? OUT_MAX : w_less[OUT_W-1:0];

    assign i_item.ready        = i_ctrl.ready;
    assign o_res.valid         = r_ovalid;
    assign o_res.others_in_set = r_out;

    assign o_stat.accept   = w_accept;
    assign o_stat.clr_last = r_clr == NODE_W'(NODES - 1);
    assign o_stat.root     = r_qpar == r_cur;
    assign o_stat.query    = r_act;
    assign o_stat.same     = r_ra == r_rb;
    assign o_stat.out_free = w_out_free;

    // Pick the next cursor; it is also the read address
    always_comb begin
        unique case (i_ctrl.cur_sel)
            CUR_HOLD: n_cur = r_cur;
            CUR_NA:   n_cur = r_na;
            CUR_NB:   n_cur = r_nb;
            CUR_PAR:  n_cur = r_qpar;
            default:  n_cur = r_cur;
        endcase
    end

    // Steer writes: clearing pass or hanging the smaller root under the larger
    always_comb begin
        w_par_we  = i_ctrl.clr || i_ctrl.link_wr;
        w_size_we = w_par_we;
        if (i_ctrl.clr) begin
            w_par_wa  = r_clr;
            w_par_wd  = r_clr;
            w_size_wa = r_clr;
            w_size_wd = SIZE_W'(1);
        end else begin
            w_par_wa  = w_a_big ? r_rb : r_ra;
            w_par_wd  = w_a_big ? r_ra : r_rb;
            w_size_wa = w_a_big ? r_ra : r_rb;
            w_size_wd = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_par_we) begin
            mem_par[w_par_wa] <= w_par_wd;
        end
        r_qpar <= mem_par[n_cur];
    end

    always_ff @(posedge i_clk) begin
        if (w_size_we) begin
            mem_size[w_size_wa] <= w_size_wd;
        end
        r_qsize <= mem_size[n_cur];
    end

    // Capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_item.action;
            r_na  <= i_item.node_a;
            r_nb  <= i_item.node_b;
        end
    end

    // Walk cursor and root capture
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_ctrl.save_sel == SAVE_RA) begin
            r_ra <= r_cur;
            r_sa <= r_qsize;
        end
        if (i_ctrl.save_sel == SAVE_RB) begin
            r_rb <= r_cur;
            r_sb <= r_qsize;
        end
    end

    // Clearing counter and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctrl.clr) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            if (i_ctrl.out_ld && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_ld && w_out_free) begin
            r_out <= w_sat;
        end
    end

    // Never link a root to itself
    a_link_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.link_wr |-> (r_ra != r_rb))
        else $error("link write with equal roots");

    // A root always carries a nonzero size when reported
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.out_ld |-> (r_sa != '0))
        else $error("reported set size is zero");

    // A result appears only after a load step
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_ctrl.out_ld))
        else $error("result valid without a load step");

endmodule
